/* rtl/core/lmts_pkg.sv */
// ----------------------------------------------------------------------------
// lmts_pkg
// Shared constants, command codes and controller/datapath interface types
// for the laxity and memory aware task scheduler.
// ----------------------------------------------------------------------------
package lmts_pkg;

	localparam int MAX_TASKS_DEF     = 16;
	localparam int MAX_STEPS_DEF     = 256;
	localparam int DEADLINE_BITS_DEF = 16;

	// internal arithmetic widths
	localparam int RD_W  = 32;  // remaining deadline, signed
	localparam int LAX_W = 34;  // laxity, signed
	localparam int FEA_W = 44;  // feasibility points and sums, signed
	localparam int PRI_W = 56;  // priority in q8.8 units, signed

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 96;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] CMD_LOAD_TASK = 2'd0;
	localparam logic [1:0] CMD_LOAD_MEM  = 2'd1;
	localparam logic [1:0] CMD_TICK      = 2'd2;

	localparam logic CFG_ALPHA      = 1'b0;
	localparam logic CFG_TASK_COUNT = 1'b1;

	typedef struct packed {
		logic load_task;
		logic load_mem;
		logic tick_start;
		logic pri_read;
		logic pri_mul;
		logic pri_cmp;
		logic feas_prep;
		logic dmax_step;
		logic cand_start;
		logic cand_next;
		logic sum_step;
		logic set_sw;
		logic commit;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		logic idx_end;
		logic run_feas;
		logic fail;
		logic cand_end;
		logic cand_ok;
		logic neg_r;
		logic out_free;
	} sts_t;

endpackage

/* rtl/core/lmts_ctrl.sv */
// ----------------------------------------------------------------------------
// lmts_ctrl
// Sequencer for one scheduler tick: release, priority scan, feasibility
// walk, optional switch to least laxity, commit and result hand-off.
// ----------------------------------------------------------------------------
module lmts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       in_cmd,
	output logic             in_ready,
	output lmts_pkg::ctl_t   ctl,
	input  lmts_pkg::sts_t   sts
);
	import lmts_pkg::*;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_PRI_RD  = 4'd1;
	localparam logic [3:0] ST_PRI_MUL = 4'd2;
	localparam logic [3:0] ST_PRI_CMP = 4'd3;
	localparam logic [3:0] ST_FEAS    = 4'd4;
	localparam logic [3:0] ST_DMAX    = 4'd5;
	localparam logic [3:0] ST_CAND    = 4'd6;
	localparam logic [3:0] ST_SUM     = 4'd7;
	localparam logic [3:0] ST_SWITCH  = 4'd8;
	localparam logic [3:0] ST_COMMIT  = 4'd9;
	localparam logic [3:0] ST_OUT     = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		in_ready  = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (in_cmd)
						CMD_LOAD_TASK: ctl.load_task = 1'b1;
						CMD_LOAD_MEM:  ctl.load_mem = 1'b1;
						CMD_TICK: begin
							ctl.tick_start = 1'b1;
							state_nxt      = ST_PRI_RD;
						end
						default: ;
					endcase
				end
			end
			ST_PRI_RD: begin
				if (sts.idx_end) begin
					state_nxt = ST_FEAS;
				end else begin
					ctl.pri_read = 1'b1;
					state_nxt    = ST_PRI_MUL;
				end
			end
			ST_PRI_MUL: begin
				ctl.pri_mul = 1'b1;
				state_nxt   = ST_PRI_CMP;
			end
			ST_PRI_CMP: begin
				ctl.pri_cmp = 1'b1;
				state_nxt   = ST_PRI_RD;
			end
			ST_FEAS: begin
				if (sts.run_feas) begin
					ctl.feas_prep = 1'b1;
					state_nxt     = ST_DMAX;
				end else begin
					state_nxt = ST_COMMIT;
				end
			end
			ST_DMAX: begin
				if (sts.idx_end) begin
					state_nxt = sts.fail ? ST_SWITCH : ST_CAND;
				end else begin
					ctl.dmax_step = 1'b1;
				end
			end
			ST_CAND: begin
				if (sts.cand_end) begin
					state_nxt = ST_COMMIT;
				end else if (sts.cand_ok) begin
					ctl.cand_start = 1'b1;
					state_nxt      = ST_SUM;
				end else begin
					ctl.cand_next = 1'b1;
				end
			end
			ST_SUM: begin
				if (sts.idx_end) begin
					if (sts.neg_r) begin
						state_nxt = ST_SWITCH;
					end else begin
						ctl.cand_next = 1'b1;
						state_nxt     = ST_CAND;
					end
				end else begin
					ctl.sum_step = 1'b1;
				end
			end
			ST_SWITCH: begin
				ctl.set_sw = 1'b1;
				state_nxt  = ST_COMMIT;
			end
			ST_COMMIT: begin
				ctl.commit = 1'b1;
				state_nxt  = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

/* rtl/core/lmts_dp.sv */
// ----------------------------------------------------------------------------
// lmts_dp
// Task table, memory profile store, priority and feasibility arithmetic,
// accumulators and the result register.
// ----------------------------------------------------------------------------
module lmts_dp #(
	parameter int MAX_TASKS     = lmts_pkg::MAX_TASKS_DEF,
	parameter int MAX_STEPS     = lmts_pkg::MAX_STEPS_DEF,
	parameter int DEADLINE_BITS = lmts_pkg::DEADLINE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lmts_pkg::ctl_t                    ctl,
	output lmts_pkg::sts_t                    sts,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [lmts_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [lmts_pkg::IN_DATA_W-1:0]    in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lmts_pkg::OUT_DATA_W-1:0]   out_data
);
	import lmts_pkg::*;

	localparam int TB  = $clog2(MAX_TASKS);
	localparam int IW  = $clog2(MAX_TASKS + 1);
	localparam int SW  = $clog2(MAX_STEPS + 1);
	localparam int AW  = $clog2(MAX_TASKS * MAX_STEPS);
	localparam int CCW = $clog2(4 * MAX_TASKS + 3);
	localparam int PBW = LAX_W + SW + 1;
	localparam logic [31:0] DL_MASK = (32'd1 << DEADLINE_BITS) - 32'd1;
	localparam logic [AW-1:0] STEP_MUL = AW'(MAX_STEPS);
	localparam logic signed [RD_W-1:0] RD_MIN = {1'b1, {(RD_W-1){1'b0}}};
	localparam logic [1:0] CAND_DL    = 2'd0;
	localparam logic [1:0] CAND_DL_M1 = 2'd1;
	localparam logic [1:0] CAND_LX    = 2'd2;
	localparam logic [1:0] CAND_LX_M1 = 2'd3;

	// input word fields
	logic [3:0]  f_task;
	logic [7:0]  f_step;
	logic [15:0] f_rel;
	logic [15:0] f_dl;
	logic [8:0]  f_exec;
	logic [15:0] f_minc;
	assign f_task = in_data[3:0];
	assign f_step = in_data[11:4];
	assign f_rel  = in_data[27:12];
	assign f_dl   = in_data[43:28];
	assign f_exec = in_data[52:44];
	assign f_minc = in_data[68:53];

	// configuration
	logic [15:0] alpha_q;
	logic [4:0]  tcnt_q;

	// task table
	logic [15:0]                  rel_q [MAX_TASKS];
	logic signed [RD_W-1:0]       rd_q  [MAX_TASKS];
	logic [SW-1:0]                ex_q  [MAX_TASKS];
	logic [SW-1:0]                st_q  [MAX_TASKS];
	logic [MAX_TASKS-1:0]         act_q;
	logic [MAX_TASKS-1:0]         fin_q;
	logic [MAX_TASKS-1:0]         mis_q;
	logic [15:0]                  prof_mem [MAX_TASKS*MAX_STEPS];

	logic [31:0] tick_q;
	logic [31:0] macc_q;
	logic [31:0] mpk_q;
	logic [15:0] swc_q;

	// scan state
	logic [IW-1:0]  idx_q;
	logic [TB-1:0]  idx_t;
	logic [CCW-1:0] cand_q;
	logic           best_v_q;
	logic           llf_v_q;
	logic           sw_q;
	logic           fail_q;
	logic           p_q;

	logic [15:0]                 prof_rd_s1;
	logic                        mzero_s1;
	logic [15:0]                 mem_s2;
	logic [31:0]                 prod_a_s2;
	logic signed [PBW-1:0]       prod_b_s2;
	logic signed [PRI_W-1:0]     best_q;
	logic [TB-1:0]               best_idx_q;
	logic [15:0]                 best_mem_q;
	logic signed [LAX_W-1:0]     llf_lax_q;
	logic [TB-1:0]               llf_idx_q;
	logic [15:0]                 llf_mem_q;

	logic signed [FEA_W-1:0] dl_q  [MAX_TASKS];
	logic signed [FEA_W-1:0] lx_q  [MAX_TASKS];
	logic signed [FEA_W-1:0] cr_q  [MAX_TASKS];
	logic signed [FEA_W-1:0] kdl_q [MAX_TASKS];
	logic signed [FEA_W-1:0] klx_q [MAX_TASKS];
	logic signed [FEA_W-1:0] dmax_q;
	logic signed [FEA_W-1:0] k_q;
	logic signed [FEA_W-1:0] r_q;

	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_valid_q;

	// combinational helpers
	logic [IW-1:0]           n_used;
	logic [MAX_TASKS-1:0]    use_m;
	logic [MAX_TASKS-1:0]    rel_hit;
	logic signed [LAX_W-1:0] lax_c   [MAX_TASKS];
	logic signed [LAX_W-1:0] lax_n_c [MAX_TASKS];
	logic signed [RD_W-1:0]  rd_n_c  [MAX_TASKS];
	logic signed [FEA_W-1:0] dl_c    [MAX_TASKS];
	logic signed [FEA_W-1:0] lx_c    [MAX_TASKS];
	logic signed [FEA_W-1:0] cr_c    [MAX_TASKS];
	logic [IW-1:0]           fin_cnt;
	logic [IW-1:0]           act_cnt;
	logic [IW-1:0]           mis_cnt;
	logic                    task_ok;
	logic                    step_ok;
	logic [TB-1:0]           ld_t;
	logic [SW-1:0]           ex_ld;
	logic [AW-1:0]           mem_waddr;
	logic [AW-1:0]           mem_raddr;
	logic [15:0]             mem_v;
	logic signed [SW:0]      rem_s;
	logic signed [PRI_W-1:0] pr_c;
	logic [CCW-1:0]          cand_m2;
	logic [TB-1:0]           cand_ti;
	logic [1:0]              cand_sel;
	logic signed [FEA_W-1:0] k_c;
	logic                    cand_tok;
	logic [15:0]             commit_mem;
	logic [32:0]             macc_sum;
	logic [31:0]             macc_n;
	logic                    all_fin;

	assign idx_t   = idx_q[TB-1:0];
	assign n_used  = (32'(tcnt_q) > MAX_TASKS) ? IW'(MAX_TASKS) : IW'(tcnt_q);
	assign task_ok = 32'(f_task) < MAX_TASKS;
	assign step_ok = 32'(f_step) < MAX_STEPS;
	assign ld_t    = TB'(f_task);
	assign ex_ld   = (32'(f_exec) > MAX_STEPS) ? SW'(MAX_STEPS) : SW'(f_exec);
	assign mem_waddr = AW'(ld_t) * STEP_MUL + AW'(f_step);
	assign mem_raddr = AW'(idx_t) * STEP_MUL + AW'(st_q[idx_t]);

	always_comb begin
		for (int i = 0; i < MAX_TASKS; i++) begin
			use_m[i] = IW'(i) < n_used;
			lax_c[i] = $signed({{(LAX_W-RD_W){rd_q[i][RD_W-1]}}, rd_q[i]})
				- $signed(LAX_W'(ex_q[i])) + $signed(LAX_W'(st_q[i]));
			rel_hit[i] = use_m[i] && !act_q[i] && !fin_q[i] && (32'(rel_q[i]) <= tick_q);
			rd_n_c[i] = (rd_q[i] != RD_MIN) ? rd_q[i] - RD_W'(1) : rd_q[i];
			lax_n_c[i] = $signed({{(LAX_W-RD_W){rd_n_c[i][RD_W-1]}}, rd_n_c[i]})
				- $signed(LAX_W'(ex_q[i])) + $signed(LAX_W'(st_q[i])) + LAX_W'(1);
		end
	end

	// deadline, laxity and remaining work as seen after this tick's step
	always_comb begin
		logic signed [FEA_W-1:0] d;
		logic [SW:0]             run;
		for (int i = 0; i < MAX_TASKS; i++) begin
			run = {1'b0, st_q[i]} + ((best_v_q && best_idx_q == TB'(i)) ? (SW+1)'(1) : '0);
			d = $signed({{(FEA_W-RD_W){rd_q[i][RD_W-1]}}, rd_q[i]});
			if (!act_q[i]) begin
				d = d + $signed(FEA_W'(rel_q[i])) - $signed(FEA_W'(tick_q));
			end
			dl_c[i] = d - FEA_W'(1);
			lx_c[i] = dl_c[i] - $signed(FEA_W'(ex_q[i])) + $signed(FEA_W'(run));
			cr_c[i] = $signed(FEA_W'(ex_q[i])) - $signed(FEA_W'(run));
		end
	end

	assign fin_cnt = IW'($countones(fin_q & use_m));
	assign act_cnt = IW'($countones(act_q & use_m));
	assign mis_cnt = IW'($countones(mis_q & use_m));
	assign all_fin = (fin_cnt == n_used);

	assign mem_v = mzero_s1 ? 16'd0 : prof_rd_s1;
	assign rem_s = $signed({1'b0, ex_q[idx_t]}) - $signed({1'b0, st_q[idx_t]});
	assign pr_c  = $signed({{(PRI_W-32){1'b0}}, prod_a_s2})
		+ ($signed({{(PRI_W-PBW){prod_b_s2[PBW-1]}}, prod_b_s2}) <<< 8);

	// candidate points: 1, the largest deadline, then per task dl, dl-1, lx, lx-1
	assign cand_m2  = cand_q - CCW'(2);
	assign cand_ti  = cand_m2[TB+1:2];
	assign cand_sel = cand_m2[1:0];

	always_comb begin
		k_c      = FEA_W'(1);
		cand_tok = 1'b1;
		if (cand_q == CCW'(0)) begin
			k_c = FEA_W'(1);
		end else if (cand_q == CCW'(1)) begin
			k_c = dmax_q;
		end else begin
			cand_tok = !fin_q[cand_ti];
			unique case (cand_sel)
				CAND_DL:    k_c = kdl_q[cand_ti];
				CAND_DL_M1: k_c = kdl_q[cand_ti] - FEA_W'(1);
				CAND_LX:    k_c = klx_q[cand_ti];
				CAND_LX_M1: k_c = klx_q[cand_ti] - FEA_W'(1);
				default:    k_c = klx_q[cand_ti];
			endcase
		end
	end

	assign commit_mem = best_v_q ? best_mem_q : 16'd0;
	assign macc_sum   = {1'b0, macc_q} + 33'(commit_mem);
	assign macc_n     = macc_sum[32] ? 32'hFFFF_FFFF : macc_sum[31:0];

	assign sts.idx_end  = idx_q >= n_used;
	assign sts.run_feas = (act_cnt > IW'(1)) && !all_fin;
	assign sts.fail     = fail_q;
	assign sts.cand_end = cand_q >= CCW'(2) + (CCW'(n_used) << 2);
	assign sts.cand_ok  = cand_tok && (k_c >= $signed(FEA_W'(1))) && (k_c <= dmax_q);
	assign sts.neg_r    = r_q[FEA_W-1];
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= '0;
			tcnt_q      <= '0;
			act_q       <= '0;
			fin_q       <= '0;
			mis_q       <= '0;
			tick_q      <= '0;
			macc_q      <= '0;
			mpk_q       <= '0;
			swc_q       <= '0;
			idx_q       <= '0;
			cand_q      <= '0;
			best_v_q    <= 1'b0;
			llf_v_q     <= 1'b0;
			sw_q        <= 1'b0;
			fail_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_TASKS; i++) begin
				st_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ALPHA) begin
					alpha_q <= cfg_data;
				end else if (cfg_index == CFG_TASK_COUNT) begin
					tcnt_q <= cfg_data[4:0];
				end
			end
			if (ctl.load_task && task_ok) begin
				st_q[ld_t]  <= '0;
				act_q[ld_t] <= 1'b0;
				fin_q[ld_t] <= 1'b0;
				mis_q[ld_t] <= 1'b0;
			end
			if (ctl.tick_start) begin
				idx_q    <= '0;
				best_v_q <= 1'b0;
				llf_v_q  <= 1'b0;
				sw_q     <= 1'b0;
				for (int i = 0; i < MAX_TASKS; i++) begin
					if (rel_hit[i]) begin
						if (lax_c[i] < 0) begin
							mis_q[i] <= 1'b1;
						end
						if (st_q[i] >= ex_q[i]) begin
							fin_q[i] <= 1'b1;
						end else begin
							act_q[i] <= 1'b1;
						end
					end
				end
			end
			if (ctl.pri_cmp) begin
				if (act_q[idx_t]) begin
					if (!best_v_q || pr_c < best_q) begin
						best_v_q <= 1'b1;
					end
					if (!llf_v_q || lax_c[idx_t] < llf_lax_q) begin
						llf_v_q <= 1'b1;
					end
				end
				idx_q <= idx_q + IW'(1);
			end
			if (ctl.feas_prep) begin
				idx_q  <= '0;
				cand_q <= '0;
				fail_q <= 1'b0;
			end
			if (ctl.dmax_step) begin
				if (!fin_q[idx_t] && lx_q[idx_t] < 0) begin
					fail_q <= 1'b1;
				end
				idx_q <= idx_q + IW'(1);
			end
			if (ctl.cand_start) begin
				idx_q <= '0;
			end
			if (ctl.cand_next) begin
				cand_q <= cand_q + CCW'(1);
			end
			if (ctl.sum_step) begin
				idx_q <= idx_q + IW'(1);
			end
			if (ctl.set_sw) begin
				sw_q <= 1'b1;
				if (swc_q != 16'hFFFF) begin
					swc_q <= swc_q + 16'd1;
				end
			end
			if (ctl.commit) begin
				macc_q <= macc_n;
				if (macc_n > mpk_q) begin
					mpk_q <= macc_n;
				end
				for (int i = 0; i < MAX_TASKS; i++) begin
					if (use_m[i] && act_q[i] && best_v_q && best_idx_q == TB'(i)) begin
						st_q[i] <= st_q[i] + SW'(1);
						if ({1'b0, st_q[i]} + (SW+1)'(1) >= {1'b0, ex_q[i]}) begin
							fin_q[i] <= 1'b1;
							act_q[i] <= 1'b0;
							if (lax_n_c[i] < 0) begin
								mis_q[i] <= 1'b1;
							end
						end
					end
				end
				if (tick_q != 32'hFFFF_FFFF) begin
					tick_q <= tick_q + 32'd1;
				end
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.load_task && task_ok) begin
			rel_q[ld_t] <= f_rel;
			rd_q[ld_t]  <= $signed({16'd0, f_dl} & DL_MASK);
			ex_q[ld_t]  <= ex_ld;
		end
		if (ctl.pri_mul) begin
			mem_s2    <= mem_v;
			prod_a_s2 <= 32'(alpha_q) * 32'(mem_v);
			prod_b_s2 <= rem_s * lax_c[idx_t];
		end
		if (ctl.pri_cmp && act_q[idx_t]) begin
			if (!best_v_q || pr_c < best_q) begin
				best_q     <= pr_c;
				best_idx_q <= idx_t;
				best_mem_q <= mem_s2;
			end
			if (!llf_v_q || lax_c[idx_t] < llf_lax_q) begin
				llf_lax_q <= lax_c[idx_t];
				llf_idx_q <= idx_t;
				llf_mem_q <= mem_s2;
			end
		end
		if (ctl.feas_prep) begin
			p_q    <= best_v_q;
			dmax_q <= '0;
			for (int i = 0; i < MAX_TASKS; i++) begin
				dl_q[i]  <= dl_c[i];
				lx_q[i]  <= lx_c[i];
				cr_q[i]  <= cr_c[i];
				kdl_q[i] <= dl_c[i];
				klx_q[i] <= lx_c[i];
			end
		end
		if (ctl.dmax_step && !fin_q[idx_t] && dl_q[idx_t] > dmax_q) begin
			dmax_q <= dl_q[idx_t];
		end
		if (ctl.cand_start) begin
			k_q <= k_c;
			r_q <= p_q ? k_c : '0;
		end
		if (ctl.sum_step && !fin_q[idx_t]) begin
			if (dl_q[idx_t] <= k_q) begin
				r_q <= r_q - cr_q[idx_t];
			end else if (lx_q[idx_t] <= k_q) begin
				r_q <= r_q - (k_q - lx_q[idx_t]);
			end
		end
		if (ctl.set_sw) begin
			best_idx_q <= llf_idx_q;
			best_mem_q <= llf_mem_q;
		end
		if (ctl.commit) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				if (use_m[i] && act_q[i]) begin
					rd_q[i] <= rd_n_c[i];
				end
			end
		end
		if (ctl.out_load) begin
			out_data_q <= {4'd0, all_fin, swc_q, 5'(mis_cnt), mpk_q, macc_q, sw_q, best_v_q,
				(best_v_q ? 4'(best_idx_q) : 4'd0)};
		end
	end

	// memory profile store
	always_ff @(posedge clk) begin
		if (ctl.load_mem && task_ok && step_ok) begin
			prof_mem[mem_waddr] <= f_minc;
		end
		if (ctl.pri_read) begin
			prof_rd_s1 <= prof_mem[mem_raddr];
			mzero_s1   <= st_q[idx_t] >= SW'(MAX_STEPS);
		end
	end

endmodule

/* rtl/core/laxity_memory_task_scheduler.sv */
// ----------------------------------------------------------------------------
// laxity_memory_task_scheduler
// Single-processor tick scheduler weighing memory use against laxity, with
// a feasibility check that falls back to least laxity first.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one command word; tuser holds the command (load task entry,
//  load memory increment, tick) and tdata holds the entry fields.
//  Loads give no result. A tick gives one result word on m_axis with the
//  chosen task, the switch flag and the running counters.
//  Configuration (alpha weight, task count) is written through cfg_we with
//  cfg_index and cfg_data while the block is idle.
// Tick sequence:
//  a tick runs a priority scan (per task: one profile memory read, one
//  multiply stage, one compare), then, when the feasibility walk runs, a
//  deadline maximum over the tasks, a switch to least laxity on failure,
//  and a sum over the tasks for each of the 4n + 2 candidate points, with
//  one sum term per cycle, before the commit and the result word.
// Reset clears all flags and counters; task entries and the profile memory
// hold nothing until loaded. When m_axis stalls, a finished result waits in
// the output register; loads are still taken, the next tick waits for it.
// ----------------------------------------------------------------------------
module laxity_memory_task_scheduler #(
	parameter int MAX_TASKS     = lmts_pkg::MAX_TASKS_DEF,
	parameter int MAX_STEPS     = lmts_pkg::MAX_STEPS_DEF,
	parameter int DEADLINE_BITS = lmts_pkg::DEADLINE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [lmts_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// task_index, step_index, release_tick, deadline_ticks, exec_steps,
	// memory_increment
	input  logic [lmts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// cmd
	input  logic [1:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// chosen_task, chosen_valid, switched_to_llf, memory_now, memory_worst,
	// missed_tasks, switch_total, all_finished
	output logic [lmts_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import lmts_pkg::*;

	ctl_t ctl;
	sts_t sts;

	lmts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (s_axis_tuser),
		.in_ready (s_axis_tready),
		.ctl      (ctl),
		.sts      (sts)
	);

	lmts_dp #(
		.MAX_TASKS     (MAX_TASKS),
		.MAX_STEPS     (MAX_STEPS),
		.DEADLINE_BITS (DEADLINE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
